>>> rtl/core/pox_pkg.sv
// ----------------------------------------------------------------------------
// pox_pkg: shared types and constants of the oriented extent block
// Sizes, sequencer states, status codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package pox_pkg;

  localparam int unsigned MAX_POINTS   = 1024;
  localparam int unsigned IDX_W        = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W        = IDX_W + 1;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned DIV_BITS     = 54;

  // Quarter turn with a full turn of 2^32, and 1/K of the CORDIC in Q30
  localparam logic signed [33:0] QUARTER_TURN = 34'sh040000000;
  localparam logic signed [35:0] INV_GAIN_Q30 = 36'sh026DD3B6A;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FEW  = 2'd1;
  localparam logic [1:0] STATUS_DROP = 2'd2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MOM,
    ST_MATH,
    ST_NORM,
    ST_SQR,
    ST_SQRT,
    ST_VEC,
    ST_ROT,
    ST_DIV,
    ST_PROJ,
    ST_FIN,
    ST_OUT
  } state_e;

  // atan(2^-i), full turn = 2^32
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/pca_2d_oriented_extent.sv
// ----------------------------------------------------------------------------
// pca_2d_oriented_extent: oriented extent of a 2D point set
// Stores a set of points, finds its principal axes and reports the extent
// of the set along each axis.
// ----------------------------------------------------------------------------
// Points enter one word per cycle while s_axis_tready is high; the word with
// s_axis_tlast closes the set. Up to 1024 points are kept, later ones are
// dropped and flagged. The second moments and the projections each take one
// pass over the stored points, both paced by the single shared 33x33
// multiplier and the one read port of the point memory; between the passes
// come the covariance terms, normalising shifts, a square root, two CORDIC
// passes and two divisions. A set of fewer than two points answers in the
// cycle after its closing word. The block takes no word from closing word
// until its result word has been taken.
module pca_2d_oriented_extent (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // point_x [15:0], point_y [31:16]
  input  logic         s_axis_tlast,   // last_point
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status [1:0], major_value [35:2], minor_value [69:36], major_dir_x [85:70],
  // major_dir_y [101:86], minor_dir_x [117:102], minor_dir_y [133:118],
  // major_length [158:134], minor_length [183:159]
  output logic [183:0] m_axis_tdata
);
  import pox_pkg::*;

  // control state
  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [2:0]         ph_q, ph_d;
  logic [5:0]         k_q, k_d;
  logic [4:0]         s_q, s_d;
  logic               sel_q, sel_d;
  logic               ovf_q, ovf_d;
  logic signed [25:0] sumx_q, sumx_d, sumy_q, sumy_d;

  // datapath
  logic [31:0]        mem_q [MAX_POINTS];
  logic [31:0]        rdata_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q, acc_q, acc_nx;
  logic [40:0]        sxx_q, syy_q;
  logic signed [41:0] sxy_q;
  logic [51:0]        a_q, b_q;
  logic signed [51:0] c_q;
  logic [20:0]        nn_q;
  logic [52:0]        ad_q, ae_q;
  logic [62:0]        sq_q;
  logic [63:0]        v_q, res_q, bit_q;
  logic [52:0]        r_q;
  logic               zero_q;
  logic signed [35:0] cx_q, cy_q;
  logic signed [33:0] z_q;
  logic [DIV_BITS-1:0] dvd_q;
  logic [21:0]        rem_q;
  logic signed [32:0] p_q, mn0_q, mx0_q, mn1_q, mx1_q;

  // result word fields
  logic [1:0]         status_q;
  logic [33:0]        majv_q, minv_q;
  logic signed [15:0] ux_q, uy_q, vx_q, vy_q;
  logic [24:0]        len0_q, len1_q;

  logic               s_acc, m_acc, room, few;
  logic signed [15:0] px, py;

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign m_acc = m_axis_tvalid && m_axis_tready;
  assign room  = (cnt_q < CNT_W'(MAX_POINTS));
  assign few   = ((room ? cnt_q + 1'b1 : cnt_q) < CNT_W'(2));
  assign px    = rdata_q[15:0];
  assign py    = rdata_q[31:16];

  assign m_axis_tdata = {len1_q, len0_q, vy_q, vx_q, uy_q, ux_q, minv_q, majv_q, status_q};

  // covariance terms
  logic [52:0]        t_w;
  logic               dneg;
  logic [51:0]        ad_full;
  logic [51:0]        cabs;
  assign t_w     = {1'b0, a_q} + {1'b0, b_q};
  assign dneg    = (a_q < b_q);
  assign ad_full = dneg ? b_q - a_q : a_q - b_q;
  assign cabs    = c_q[51] ? 52'(-c_q) : 52'(c_q);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_MOM: begin
        case (ph_q)
          3'd1: begin mul_a = 33'(px); mul_b = 33'(px); end
          3'd2: begin mul_a = 33'(py); mul_b = 33'(py); end
          3'd3: begin mul_a = 33'(px); mul_b = 33'(py); end
          default: ;
        endcase
      end
      ST_MATH: begin
        mul_a = {22'b0, cnt_q};
        case (k_q[4:1])
          4'd0: mul_b = {9'b0, sxx_q[23:0]};
          4'd1: mul_b = {16'b0, sxx_q[40:24]};
          4'd2: begin mul_a = 33'(sumx_q); mul_b = 33'(sumx_q); end
          4'd3: mul_b = {9'b0, syy_q[23:0]};
          4'd4: mul_b = {16'b0, syy_q[40:24]};
          4'd5: begin mul_a = 33'(sumy_q); mul_b = 33'(sumy_q); end
          4'd6: mul_b = {9'b0, sxy_q[23:0]};
          4'd7: mul_b = 33'($signed(sxy_q[41:24]));
          4'd8: begin mul_a = 33'(sumx_q); mul_b = 33'(sumy_q); end
          4'd9: mul_b = {22'b0, cnt_q};
          default: mul_b = '0;
        endcase
      end
      ST_SQR: begin
        if (k_q == 6'd0) begin
          mul_a = {2'b0, ad_q[30:0]};
          mul_b = {2'b0, ad_q[30:0]};
        end else begin
          mul_a = {2'b0, ae_q[30:0]};
          mul_b = {2'b0, ae_q[30:0]};
        end
      end
      ST_PROJ: begin
        case (ph_q)
          3'd1: begin mul_a = 33'(px); mul_b = 33'(ux_q); end
          3'd2: begin mul_a = 33'(py); mul_b = 33'(uy_q); end
          3'd3: begin mul_a = 33'(px); mul_b = 33'(vx_q); end
          3'd4: begin mul_a = 33'(py); mul_b = 33'(vy_q); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // accumulate partial products of n*S - S*S
  always_comb begin
    case (k_q[4:1]) inside
      4'd0, 4'd3, 4'd6, 4'd9: acc_nx = prod_q;
      4'd1, 4'd4, 4'd7:       acc_nx = acc_q + (prod_q <<< 24);
      default:                acc_nx = acc_q - prod_q;
    endcase
  end

  // square root digit step
  logic [63:0] trial, v_nx, res_nx;
  logic        sq_ge;
  logic [55:0] r_full;
  assign trial  = res_q + bit_q;
  assign sq_ge  = (v_q >= trial);
  assign v_nx   = sq_ge ? v_q - trial : v_q;
  assign res_nx = sq_ge ? (res_q >> 1) + bit_q : res_q >> 1;
  assign r_full = 56'(res_nx[31:0]) << s_q;

  // CORDIC micro-rotation, shared by vectoring and rotation
  logic signed [35:0] xs, ys, cx_nx, cy_nx;
  logic signed [33:0] atn, z_nx, h_raw, h_w;
  logic               add_m, vec;
  assign vec   = (state_q == ST_VEC);
  assign xs    = cx_q >>> k_q[4:0];
  assign ys    = cy_q >>> k_q[4:0];
  assign atn   = 34'(atan_lut(k_q[4:0]));
  assign add_m = vec ? (cy_q >= 0) : (z_q < 0);
  assign cx_nx = add_m ? cx_q + ys : cx_q - ys;
  assign cy_nx = add_m ? cy_q - xs : cy_q + xs;
  assign z_nx  = (vec && zero_q) ? z_q : (add_m ? z_q + atn : z_q - atn);
  assign h_raw = z_nx >>> 1;
  assign h_w   = (h_raw > QUARTER_TURN || h_raw <= -QUARTER_TURN) ? QUARTER_TURN : h_raw;

  // vectoring start point
  logic signed [32:0] dv, ev;
  assign dv = dneg     ? -$signed({2'b0, ad_q[30:0]}) : $signed({2'b0, ad_q[30:0]});
  assign ev = c_q[51]  ? -$signed({2'b0, ae_q[30:0]}) : $signed({2'b0, ae_q[30:0]});

  // round a Q30 value to Q1.15 with saturation
  function automatic logic signed [15:0] to_q15(input logic signed [35:0] v);
    logic signed [35:0] q;
    q = (v + 36'sd16384) >>> 15;
    if (q > 36'sd32767)       return 16'sh7FFF;
    else if (q < -36'sd32768) return 16'sh8000;
    else                      return q[15:0];
  endfunction

  logic signed [15:0] ux_w, uy_w, ux_f, uy_f;
  assign ux_w = to_q15(cx_nx);
  assign uy_w = to_q15(cy_nx);
  assign ux_f = (ux_w <= 0) ? 16'sd0 : ux_w;
  assign uy_f = (ux_w <= 0) ? 16'sh7FFF : uy_w;

  // dividends of the principal values
  logic [53:0] sum_tr;
  logic [DIV_BITS-1:0] dvd_maj, dvd_min;
  assign sum_tr  = {1'b0, t_w} + {1'b0, r_q};
  assign dvd_maj = {1'b0, sum_tr[53:1]} + {34'b0, nn_q[20:1]};
  assign dvd_min = {2'b0, t_w[52:1] - r_q[52:1] - 52'((~t_w[0]) & r_q[0])}
                   + {34'b0, nn_q[20:1]};

  // restoring divide step
  logic [21:0] rs;
  logic        dge;
  logic [DIV_BITS-1:0] dvd_nx;
  logic [33:0] quo_sat;
  assign rs      = {rem_q[20:0], dvd_q[DIV_BITS-1]};
  assign dge     = (rs >= {1'b0, nn_q});
  assign dvd_nx  = {dvd_q[DIV_BITS-2:0], dge};
  assign quo_sat = (dvd_nx[DIV_BITS-1:34] != '0) ? '1 : dvd_nx[33:0];

  // projections and extent
  logic signed [32:0] pj;
  logic               first;
  logic [33:0]        ext0, ext1;
  logic [34:0]        lr0, lr1;
  assign pj    = p_q + prod_q[32:0];
  assign first = (idx_q == '0);
  assign ext0  = 34'({mx0_q[32], mx0_q} - {mn0_q[32], mn0_q});
  assign ext1  = 34'({mx1_q[32], mx1_q} - {mn1_q[32], mn1_q});
  assign lr0   = {1'b0, ext0} + 35'd64;
  assign lr1   = {1'b0, ext1} + 35'd64;

  logic last_pt;
  assign last_pt = (idx_q == cnt_q - 1'b1);

  // next state and sequencer counters
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    ph_d    = ph_q;
    k_d     = k_q + 1'b1;
    s_d     = s_q;
    sel_d   = sel_q;
    ovf_d   = ovf_q;
    sumx_d  = sumx_q;
    sumy_d  = sumy_q;
    unique case (state_q)
      ST_LOAD: begin
        k_d = '0;
        s_d = '0;
        if (s_acc) begin
          if (room) begin
            cnt_d  = cnt_q + 1'b1;
            sumx_d = sumx_q + 26'(signed'(s_axis_tdata[15:0]));
            sumy_d = sumy_q + 26'(signed'(s_axis_tdata[31:16]));
          end else begin
            ovf_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = few ? ST_OUT : ST_MOM;
            idx_d   = '0;
            ph_d    = '0;
          end
        end
      end
      ST_MOM: begin
        if (ph_q == 3'd4) begin
          ph_d = '0;
          if (last_pt) begin
            state_d = ST_MATH;
            k_d     = '0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          ph_d = ph_q + 1'b1;
        end
      end
      ST_MATH: if (k_q == 6'd19) state_d = ST_NORM;
      ST_NORM: begin
        if (ad_q[52:31] != '0 || ae_q[52:31] != '0) begin
          s_d = s_q + 1'b1;
        end else begin
          state_d = ST_SQR;
          k_d     = '0;
        end
      end
      ST_SQR: begin
        if (k_q == 6'd2) begin
          state_d = ST_SQRT;
          k_d     = '0;
        end
      end
      ST_SQRT: begin
        if (k_q == 6'd31) begin
          state_d = ST_VEC;
          k_d     = '0;
        end
      end
      ST_VEC: begin
        if (k_q == 6'(CORDIC_STEPS - 1)) begin
          state_d = ST_ROT;
          k_d     = '0;
        end
      end
      ST_ROT: begin
        if (k_q == 6'(CORDIC_STEPS - 1)) begin
          state_d = ST_DIV;
          k_d     = '0;
          sel_d   = 1'b0;
        end
      end
      ST_DIV: begin
        if (k_q == 6'(DIV_BITS - 1)) begin
          k_d = '0;
          if (sel_q) begin
            state_d = ST_PROJ;
            idx_d   = '0;
            ph_d    = '0;
          end else begin
            sel_d = 1'b1;
          end
        end
      end
      ST_PROJ: begin
        if (ph_q == 3'd5) begin
          ph_d = '0;
          if (last_pt) state_d = ST_FIN;
          else         idx_d = idx_q + 1'b1;
        end else begin
          ph_d = ph_q + 1'b1;
        end
      end
      ST_FIN: state_d = ST_OUT;
      ST_OUT: begin
        if (m_acc) begin
          state_d = ST_LOAD;
          cnt_d   = '0;
          ovf_d   = 1'b0;
          sumx_d  = '0;
          sumy_d  = '0;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      idx_q   <= '0;
      ph_q    <= '0;
      k_q     <= '0;
      s_q     <= '0;
      sel_q   <= 1'b0;
      ovf_q   <= 1'b0;
      sumx_q  <= '0;
      sumy_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      ph_q    <= ph_d;
      k_q     <= k_d;
      s_q     <= s_d;
      sel_q   <= sel_d;
      ovf_q   <= ovf_d;
      sumx_q  <= sumx_d;
      sumy_q  <= sumy_d;
    end
  end

  // point memory: write at the fill count, read at the pass index
  always_ff @(posedge clk_i) begin
    if (s_acc && room) mem_q[cnt_q[IDX_W-1:0]] <= s_axis_tdata;
    rdata_q <= mem_q[idx_q[IDX_W-1:0]];
  end

  // shared multiplier
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_LOAD: begin
        sxx_q <= '0;
        syy_q <= '0;
        sxy_q <= '0;
        if (s_acc && s_axis_tlast && few) begin
          status_q <= STATUS_FEW;
          majv_q   <= '0;
          minv_q   <= '0;
          ux_q     <= '0;
          uy_q     <= '0;
          vx_q     <= '0;
          vy_q     <= '0;
          len0_q   <= '0;
          len1_q   <= '0;
        end
      end
      ST_MOM: begin
        case (ph_q)
          3'd2: sxx_q <= sxx_q + prod_q[40:0];
          3'd3: syy_q <= syy_q + prod_q[40:0];
          3'd4: sxy_q <= sxy_q + prod_q[41:0];
          default: ;
        endcase
      end
      ST_MATH: begin
        if (k_q[0]) begin
          acc_q <= acc_nx;
          case (k_q[4:1])
            4'd2: a_q <= acc_nx[51:0];
            4'd5: b_q <= acc_nx[51:0];
            4'd8: c_q <= acc_nx[51:0];
            4'd9: nn_q <= prod_q[20:0];
            default: ;
          endcase
        end
        // magnitudes for the square root and the angle
        if (k_q == 6'd19) begin
          ad_q <= {1'b0, ad_full};
          ae_q <= {cabs, 1'b0};
        end
      end
      ST_NORM: begin
        if (ad_q[52:31] != '0 || ae_q[52:31] != '0) begin
          ad_q <= ad_q >> 1;
          ae_q <= ae_q >> 1;
        end
      end
      ST_SQR: begin
        if (k_q == 6'd1) sq_q <= prod_q[62:0];
        if (k_q == 6'd2) begin
          v_q    <= {1'b0, sq_q + prod_q[62:0]};
          res_q  <= '0;
          bit_q  <= 64'h4000_0000_0000_0000;
          zero_q <= (ad_q[30:0] == '0) && (ae_q[30:0] == '0);
          // fold the vector into the right half plane
          if (dv < 0) begin
            if (ev >= 0) begin
              cx_q <= 36'(ev);
              cy_q <= 36'(-dv);
              z_q  <= QUARTER_TURN;
            end else begin
              cx_q <= 36'(-ev);
              cy_q <= 36'(dv);
              z_q  <= -QUARTER_TURN;
            end
          end else begin
            cx_q <= 36'(dv);
            cy_q <= 36'(ev);
            z_q  <= '0;
          end
        end
      end
      ST_SQRT: begin
        v_q   <= v_nx;
        res_q <= res_nx;
        bit_q <= bit_q >> 2;
        if (k_q == 6'd31) r_q <= (r_full > {3'b0, t_w}) ? t_w : r_full[52:0];
      end
      ST_VEC: begin
        if (!zero_q) begin
          cx_q <= cx_nx;
          cy_q <= cy_nx;
        end
        z_q <= z_nx;
        // halve the angle and start the unit vector
        if (k_q == 6'(CORDIC_STEPS - 1)) begin
          z_q  <= h_w;
          cx_q <= INV_GAIN_Q30;
          cy_q <= '0;
        end
      end
      ST_ROT: begin
        cx_q <= cx_nx;
        cy_q <= cy_nx;
        z_q  <= z_nx;
        if (k_q == 6'(CORDIC_STEPS - 1)) begin
          ux_q  <= ux_f;
          uy_q  <= uy_f;
          vx_q  <= (uy_f == 16'sh8000) ? 16'sh7FFF : -uy_f;
          vy_q  <= ux_f;
          dvd_q <= dvd_maj;
          rem_q <= '0;
        end
      end
      ST_DIV: begin
        rem_q <= dge ? rs - {1'b0, nn_q} : rs;
        dvd_q <= dvd_nx;
        if (k_q == 6'(DIV_BITS - 1)) begin
          if (sel_q) begin
            minv_q <= quo_sat;
          end else begin
            majv_q <= quo_sat;
            dvd_q  <= dvd_min;
            rem_q  <= '0;
          end
        end
      end
      ST_PROJ: begin
        case (ph_q)
          3'd2: p_q <= prod_q[32:0];
          3'd3: begin
            p_q <= pj;
            if (first || pj < mn0_q) mn0_q <= pj;
            if (first || pj > mx0_q) mx0_q <= pj;
          end
          3'd4: p_q <= prod_q[32:0];
          3'd5: begin
            if (first || pj < mn1_q) mn1_q <= pj;
            if (first || pj > mx1_q) mx1_q <= pj;
          end
          default: ;
        endcase
      end
      ST_FIN: begin
        status_q <= ovf_q ? STATUS_DROP : STATUS_OK;
        len0_q   <= (lr0[34:32] != '0) ? '1 : lr0[31:7];
        len1_q   <= (lr1[34:32] != '0) ? '1 : lr1[31:7];
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/pox_checker.sv
// ----------------------------------------------------------------------------
// pox_checker: port-level checks of the oriented extent block
// Watches the stream ports for sequencing and result word rules.
// ----------------------------------------------------------------------------
module pox_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [183:0] m_axis_tdata
);

  // never take a point while a result word is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready while result pending");

  // closing word stops intake
  a_last_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("intake continued after closing word");

  // taken result reopens intake
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> (s_axis_tready && !m_axis_tvalid))
    else $error("intake not reopened after result");

  // stalled result word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result word changed while stalled");

endmodule

bind pca_2d_oriented_extent pox_checker u_pox_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> dv/tb_pca_2d_oriented_extent.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pca_2d_oriented_extent: self-checking bench of the oriented extent block
// Streams point sets into the block and predicts each result word. The sets
// are directed corner cases, one set past store capacity, then random lines,
// clusters and full-range scatter. Both stream sides idle in several phases,
// and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module tb_pca_2d_oriented_extent;
  import pox_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned STORE_DEPTH = MAX_POINTS;
  localparam int unsigned ROT_STEPS   = CORDIC_STEPS;
  localparam longint      QTURN       = 64'sh40000000;
  localparam longint      INV_GAIN    = 64'sh26DD3B6A;

  // Phases of idling on both stream sides
  typedef enum int {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [24:0] minor_len;
    logic [24:0] major_len;
    logic [15:0] minor_dy;
    logic [15:0] minor_dx;
    logic [15:0] major_dy;
    logic [15:0] major_dx;
    logic [33:0] minor_val;
    logic [33:0] major_val;
    logic [1:0]  status;
  } extent_word_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the point set and holds the expected result words
  // --------------------------------------------------------------------------
  class extent_scoreboard;
    logic [31:0]  pts[STORE_DEPTH];
    longint       acc_x, acc_y;
    int unsigned  n_pts;
    bit           dropped;
    extent_word_t exp_q[$];
    int unsigned  n_errors;
    longint       atan_q[32];

    function new();
      atan_q = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                 64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                 64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
                 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
                 64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005,
                 64'h00000003, 64'h00000001, 64'h00000001, 64'h00000000};
      acc_x = 0; acc_y = 0; n_pts = 0; dropped = 0; n_errors = 0;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'h1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function automatic longint q15(longint v);
      longint q;
      q = (v + 16384) >>> 15;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q;
    endfunction

    function automatic longint unsigned eigen(longint unsigned t, longint unsigned r,
                                               bit plus, longint unsigned nn);
      longint unsigned half, val;
      if (plus) half = (t >> 1) + (r >> 1) + (((t & 1) + (r & 1)) >> 1);
      else half = (t - r) >> 1;
      val = (half + (nn >> 1)) / nn;
      return (val > 64'h3FFFFFFFF) ? 64'h3FFFFFFFF : val;
    endfunction

    function automatic logic [24:0] extent_q8(longint ext);
      longint unsigned v;
      v = (longint'(ext) + 64) >> 7;
      return (v > 64'h1FFFFFF) ? 25'h1FFFFFF : v[24:0];
    endfunction

    // Principal axes and extents of the current set
    function automatic extent_word_t solve_set();
      extent_word_t w;
      longint sxx, syy, sxy, x, y, a, b, c, t, dd, ad, ae, r, nn, d, e;
      longint z, h, cx, cy, xs, ys, ux, uy, vx, vy, p0, p1, mn0, mx0, mn1, mx1;
      int s;
      w = '0;
      if (n_pts < 2) begin
        w.status = STATUS_FEW;
        return w;
      end
      sxx = 0; syy = 0; sxy = 0;
      for (int i = 0; i < n_pts; i++) begin
        x = longint'($signed(pts[i][15:0]));
        y = longint'($signed(pts[i][31:16]));
        sxx += x * x; syy += y * y; sxy += x * y;
      end
      a = n_pts * sxx - acc_x * acc_x;
      b = n_pts * syy - acc_y * acc_y;
      c = n_pts * sxy - acc_x * acc_y;
      t = a + b;
      dd = a - b;
      ad = (dd < 0) ? -dd : dd;
      ae = 2 * ((c < 0) ? -c : c);
      s = 0;
      while ((ad >>> s) >= (64'sd1 <<< 31) || (ae >>> s) >= (64'sd1 <<< 31)) s++;
      ad = ad >>> s;
      ae = ae >>> s;
      r = longint'(int_sqrt(ad * ad + ae * ae)) <<< s;
      if (r > t) r = t;
      nn = n_pts * n_pts;
      d = (dd < 0) ? -ad : ad;
      e = (c < 0) ? -ae : ae;
      // Vectoring pass: angle of (d, e)
      z = 0;
      if (d != 0 || e != 0) begin
        if (d < 0) begin
          if (e >= 0) begin x = e; y = -d; z = QTURN; end
          else begin x = -e; y = d; z = -QTURN; end
        end else begin
          x = d; y = e;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
          xs = x >>> i; ys = y >>> i;
          if (y >= 0) begin x += ys; y -= xs; z += atan_q[i]; end
          else begin x -= ys; y += xs; z -= atan_q[i]; end
        end
      end
      // Rotation pass: unit vector at half the angle
      h = z >>> 1;
      if (h > QTURN || h <= -QTURN) h = QTURN;
      cx = INV_GAIN; cy = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
        xs = cx >>> i; ys = cy >>> i;
        if (h >= 0) begin cx -= ys; cy += xs; h -= atan_q[i]; end
        else begin cx += ys; cy -= xs; h += atan_q[i]; end
      end
      ux = q15(cx); uy = q15(cy);
      if (ux <= 0) begin ux = 0; uy = 32767; end
      vx = (-uy > 32767) ? 32767 : -uy;
      vy = ux;
      mn0 = 0; mx0 = 0; mn1 = 0; mx1 = 0;
      for (int i = 0; i < n_pts; i++) begin
        x = longint'($signed(pts[i][15:0]));
        y = longint'($signed(pts[i][31:16]));
        p0 = x * ux + y * uy;
        p1 = x * vx + y * vy;
        if (i == 0) begin
          mn0 = p0; mx0 = p0; mn1 = p1; mx1 = p1;
        end else begin
          if (p0 < mn0) mn0 = p0;
          if (p0 > mx0) mx0 = p0;
          if (p1 < mn1) mn1 = p1;
          if (p1 > mx1) mx1 = p1;
        end
      end
      w.status    = dropped ? STATUS_DROP : STATUS_OK;
      w.major_val = 34'(eigen(t, r, 1'b1, nn));
      w.minor_val = 34'(eigen(t, r, 1'b0, nn));
      w.major_dx  = ux[15:0];
      w.major_dy  = uy[15:0];
      w.minor_dx  = vx[15:0];
      w.minor_dy  = vy[15:0];
      w.major_len = extent_q8(mx0 - mn0);
      w.minor_len = extent_q8(mx1 - mn1);
      return w;
    endfunction

    // Note one accepted point word
    function void note_point(logic [31:0] data, logic last);
      if (n_pts < STORE_DEPTH) begin
        pts[n_pts] = data;
        n_pts++;
        acc_x += longint'($signed(data[15:0]));
        acc_y += longint'($signed(data[31:16]));
      end else begin
        dropped = 1'b1;
      end
      if (last) begin
        exp_q.push_back(solve_set());
        acc_x = 0; acc_y = 0; n_pts = 0; dropped = 0;
      end
    endfunction

    function void report(string field, longint unsigned want, longint unsigned got);
      n_errors++;
      if (n_errors <= 10)
        $display("mismatch %s: expected 0x%0h, actual 0x%0h", field, want, got);
    endfunction

    // Check one accepted result word against the oldest expectation
    function void check_result(logic [183:0] data);
      extent_word_t got, want;
      got = data;
      if (exp_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result word 0x%0h", data);
        return;
      end
      want = exp_q.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.major_val !== want.major_val)
        report("major_value", want.major_val, got.major_val);
      if (got.minor_val !== want.minor_val)
        report("minor_value", want.minor_val, got.minor_val);
      if (got.major_dx !== want.major_dx) report("major_dir_x", want.major_dx, got.major_dx);
      if (got.major_dy !== want.major_dy) report("major_dir_y", want.major_dy, got.major_dy);
      if (got.minor_dx !== want.minor_dx) report("minor_dir_x", want.minor_dx, got.minor_dx);
      if (got.minor_dy !== want.minor_dy) report("minor_dir_y", want.minor_dy, got.minor_dy);
      if (got.major_len !== want.major_len)
        report("major_length", want.major_len, got.major_len);
      if (got.minor_len !== want.minor_len)
        report("minor_length", want.minor_len, got.minor_len);
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [183:0] m_axis_tdata;

  extent_scoreboard sb = new();
  idle_mode_e       mode = IDLE_NONE;
  bit               hold_go = 1'b0;
  bit               hold_done = 1'b0;
  int unsigned      hold_cycles = 0;
  int unsigned      cycle_cnt = 0;
  int unsigned      n_sent = 0;

  pca_2d_oriented_extent u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Drive output ready: long hold-off first, else idle by phase
  always @(negedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_cycles <= 3000 - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (mode == IDLE_SINK) begin
      m_axis_tready <= ($urandom_range(99) >= 62);
    end else if (mode == IDLE_BOTH) begin
      m_axis_tready <= ($urandom_range(99) >= 8);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Check each result word taken
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one point word, waiting out the handshake; returns at a falling edge
  task automatic send_point(logic [15:0] x, logic [15:0] y, logic last);
    bit taken;
    while ((mode == IDLE_SRC && $urandom_range(99) < 62) ||
           (mode == IDLE_BOTH && $urandom_range(99) < 8)) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {y, x};
    s_axis_tlast  = last;
    taken = 0;
    while (!taken) begin
      @(posedge clk_i);
      taken = s_axis_tready;
      if (taken) sb.note_point({y, x}, last);
      @(negedge clk_i);
    end
    n_sent++;
  endtask

  function automatic logic [15:0] clip16(int v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // One random set: a noisy line, a tight cluster, or full-range scatter
  task automatic send_random_set(int unsigned count);
    int shape, ox, oy, dx, dy, k, nz;
    shape = $urandom_range(3);
    ox = $urandom_range(4000) - 2000;
    oy = $urandom_range(4000) - 2000;
    dx = $urandom_range(600) - 300;
    dy = $urandom_range(600) - 300;
    nz = $urandom_range(20);
    for (int i = 0; i < count; i++) begin
      logic [15:0] px, py;
      k = $urandom_range(200) - 100;
      case (shape)
        0: begin
          px = clip16(ox + k * dx + $urandom_range(2 * nz) - nz);
          py = clip16(oy + k * dy + $urandom_range(2 * nz) - nz);
        end
        1: begin
          px = clip16(ox * 16 + $urandom_range(2 * nz) - nz);
          py = clip16(oy * 16 + $urandom_range(2 * nz) - nz);
        end
        default: begin
          px = 16'($urandom());
          py = 16'($urandom());
        end
      endcase
      send_point(px, py, i == count - 1);
    end
  endtask

  initial begin
    int unsigned n_sets;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed sets
    send_point(16'sd7, -16'sd3, 1'b1);                 // lone point
    send_point(16'h7FFF, 16'h7FFF, 1'b0);              // full diagonal
    send_point(16'h8000, 16'h8000, 1'b1);
    send_point(16'h0000, 16'h8000, 1'b0);              // vertical axis
    send_point(16'h0000, 16'h7FFF, 1'b1);
    send_point(16'h8000, 16'h0000, 1'b0);              // horizontal axis
    send_point(16'h7FFF, 16'h0000, 1'b1);
    send_point(16'sd5, 16'sd5, 1'b0);                  // coincident points
    send_point(16'sd5, 16'sd5, 1'b1);
    send_point(16'sd1, 16'sd0, 1'b0);                  // isotropic cross
    send_point(-16'sd1, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd1, 1'b0);
    send_point(16'sd0, -16'sd1, 1'b1);
    send_point(16'sd100, -16'sd100, 1'b0);             // anti-diagonal
    send_point(-16'sd100, 16'sd100, 1'b1);
    send_point(16'h8000, 16'h7FFF, 1'b0);              // opposite corners
    send_point(16'h7FFF, 16'h8000, 1'b0);
    send_point(16'h0000, 16'h0000, 1'b1);

    // Past store capacity: the tail is dropped
    send_random_set(STORE_DEPTH + 6);

    // Output held off while sets keep coming: the input backs up
    hold_go = 1'b1;
    for (int i = 0; i < 4; i++) send_random_set($urandom_range(2, 10));

    // Random sets through the idling phases
    n_sets = 0;
    while (n_sent < 1550) begin
      mode = idle_mode_e'((n_sets / 12) % 4);
      case ($urandom_range(9))
        0:       send_random_set(1);
        1:       send_random_set($urandom_range(20, 60));
        default: send_random_set($urandom_range(2, 12));
      endcase
      n_sets++;
    end
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;
    mode = IDLE_NONE;

    while (sb.exp_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
